[rtl/k_way_sorted_merge_unit_defines.svh]
// ----------------------------------------------------------------------------
// k-way sorted merge unit: assertion macros
// Shared property wrappers, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_UNIT_DEFINES_SVH
`define K_WAY_SORTED_MERGE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the cycle after
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Sizes, result codes and address helper for the k-way sorted merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  // list geometry
  localparam int LIST_COUNT = 8;
  localparam int LIST_DEPTH = 64;

  // payload widths fixed by the interface
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 3;
  localparam int STAT_W = 2;

  // derived widths
  localparam int LIST_W  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int POS_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int MEM_D   = LIST_COUNT * LIST_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_D);
  // spare top bit so the list count itself fits for the range check
  localparam int IDX_EXT = ((LIST_W > IDX_W) ? LIST_W : IDX_W) + 1;
  localparam int LVL_N   = LIST_W;
  localparam int CAND_N  = 1 << LVL_N;
  localparam int LVL_CW  = $clog2(LVL_N + 1);

  // operation codes carried on the input word
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ORDER = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // element store address of a list slot
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LIST_W-1:0] list,
                                                  input logic [POS_W-1:0] pos);
    return ADDR_W'(ADDR_W'(list) * ADDR_W'(LIST_DEPTH)) + ADDR_W'(pos);
  endfunction

endpackage

`default_nettype wire

[rtl/kwm_ram.sv]
// ----------------------------------------------------------------------------
// kwm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/k_way_sorted_merge_unit.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit
// Bounded ascending lists held in one element RAM, merged on demand.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser selects the operation
//   (load or take) and the list; s_tdata carries the value for a load.
//   Every input word gives exactly one result word on m_tvalid/m_tready:
//   m_tuser carries status and source list, m_tdata the merged value.
//   A load is checked against the list's fill count and last value and
//   written to the element RAM; its result shows in the cycle after accept,
//   and a new word is taken in that same cycle if the receiver takes the
//   result, so loads run one a cycle.
//   A take starts from a cache of the list heads and reduces it through a
//   registered pairwise tree, one level a cycle (log2 of the list count,
//   three levels for eight lists), then commits and registers the result.
//   If the winning list still holds elements, a refill state then reads
//   the next head from the element RAM before the next word is taken;
//   if the list empties or all lists are empty, the block returns to
//   idle straight from the commit.
//   Reset clears the fill counts and read positions, so all lists are
//   empty; no clearing pass is needed. A stalled receiver holds the result
//   register and the block takes no new word until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_way_sorted_merge_unit_defines.svh"

module k_way_sorted_merge_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [kwm_pkg::VAL_W-1:0]   s_tdata,   // value
  input  wire logic [kwm_pkg::IDX_W:0]     s_tuser,   // operation, list_index
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [kwm_pkg::VAL_W-1:0]   m_tdata,   // merged_value
  output logic [kwm_pkg::STAT_W+kwm_pkg::IDX_W-1:0] m_tuser // status, source_list
);
  import kwm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_COMMIT,
    S_REFILL
  } state_t;

  state_t state;

  // per-list control and head cache
  logic signed [VAL_W-1:0] head_val [LIST_COUNT];
  logic signed [VAL_W-1:0] last_val [LIST_COUNT];
  logic [POS_W-1:0]        rd_pos   [LIST_COUNT];
  logic [CNT_W-1:0]        fill_cnt [LIST_COUNT];

  // reduction tree registers
  logic signed [VAL_W-1:0] cand_val [CAND_N];
  logic [LIST_W-1:0]       cand_idx [CAND_N];
  logic                    cand_ok  [CAND_N];
  logic signed [VAL_W-1:0] red_val  [CAND_N];
  logic [LIST_W-1:0]       red_idx  [CAND_N];
  logic                    red_ok   [CAND_N];
  logic [LVL_CW-1:0]       lvl;
  logic [LIST_W-1:0]       take_list;

  // result fields
  status_t                 out_status;
  logic [IDX_W-1:0]        out_src;
  logic                    res_set;

  // input decode
  logic                    s_fire;
  op_t                     in_op;
  logic [IDX_EXT-1:0]      idx_ext;
  logic [LIST_W-1:0]       list_sel;
  logic                    list_ok;
  logic [CNT_W-1:0]        sel_fill;
  logic [POS_W-1:0]        sel_pos;
  logic signed [VAL_W-1:0] sel_last;
  logic signed [VAL_W-1:0] in_val;
  logic                    is_full;
  logic                    is_order;
  logic [SUM_W-1:0]        wsum;
  logic [POS_W-1:0]        wpos;

  // take commit
  logic [LIST_W-1:0]       win;
  logic [POS_W-1:0]        win_pos;
  logic [POS_W-1:0]        pos_inc;
  logic [CNT_W-1:0]        win_fill;

  // element RAM ports
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  // handshake
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tuser  = {out_src, out_status};

  // a result word is loaded on a load accept or a take commit
  assign res_set  = (s_fire && (in_op == OP_LOAD)) || (state == S_COMMIT);

  // load checks against the selected list
  always_comb begin
    in_op    = op_t'(s_tuser[0]);
    idx_ext  = IDX_EXT'(s_tuser[IDX_W:1]);
    list_sel = idx_ext[LIST_W-1:0];
    list_ok  = idx_ext < IDX_EXT'(LIST_COUNT);
    sel_fill = fill_cnt[list_sel];
    sel_pos  = rd_pos[list_sel];
    sel_last = last_val[list_sel];
    in_val   = $signed(s_tdata);
    is_full  = !list_ok || (sel_fill >= CNT_W'(LIST_DEPTH));
    is_order = (sel_fill != '0) && (in_val < sel_last);
    wsum     = SUM_W'(sel_pos) + SUM_W'(sel_fill);
    if (wsum >= SUM_W'(LIST_DEPTH)) begin
      wpos = POS_W'(wsum - SUM_W'(LIST_DEPTH));
    end else begin
      wpos = POS_W'(wsum);
    end
  end

  // one tree level: lower pair member wins ties
  always_comb begin
    for (int i = 0; i < CAND_N; i++) begin
      red_val[i] = '0;
      red_idx[i] = '0;
      red_ok[i]  = 1'b0;
    end
    for (int i = 0; i < CAND_N / 2; i++) begin
      if (cand_ok[2*i] && (!cand_ok[2*i+1] || !(cand_val[2*i+1] < cand_val[2*i]))) begin
        red_val[i] = cand_val[2*i];
        red_idx[i] = cand_idx[2*i];
        red_ok[i]  = 1'b1;
      end else begin
        red_val[i] = cand_val[2*i+1];
        red_idx[i] = cand_idx[2*i+1];
        red_ok[i]  = cand_ok[2*i+1];
      end
    end
  end

  // winner bookkeeping and next head address
  always_comb begin
    win      = cand_idx[0];
    win_pos  = rd_pos[win];
    win_fill = fill_cnt[win];
    if (win_pos == POS_W'(LIST_DEPTH - 1)) begin
      pos_inc = '0;
    end else begin
      pos_inc = win_pos + POS_W'(1);
    end
  end

  assign ram_we    = s_fire && (in_op == OP_LOAD) && !is_full && !is_order;
  assign ram_waddr = slot_addr(list_sel, wpos);
  assign ram_raddr = slot_addr(win, pos_inc);

  // element store
  kwm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MEM_D)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state machine, list bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      lvl      <= '0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        fill_cnt[i] <= '0;
        rd_pos[i]   <= '0;
      end
    end else begin
      if (res_set) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            if (in_op == OP_LOAD) begin
              m_tdata  <= '0;
              out_src  <= '0;
              if (is_full) begin
                out_status <= STAT_FULL;
              end else if (is_order) begin
                out_status <= STAT_ORDER;
              end else begin
                out_status         <= STAT_OK;
                fill_cnt[list_sel] <= sel_fill + CNT_W'(1);
                last_val[list_sel] <= in_val;
                if (sel_fill == '0) begin
                  head_val[list_sel] <= in_val;
                end
              end
            end else begin
              for (int i = 0; i < LIST_COUNT; i++) begin
                cand_val[i] <= head_val[i];
                cand_idx[i] <= LIST_W'(i);
                cand_ok[i]  <= fill_cnt[i] != '0;
              end
              for (int i = LIST_COUNT; i < CAND_N; i++) begin
                cand_val[i] <= '0;
                cand_idx[i] <= '0;
                cand_ok[i]  <= 1'b0;
              end
              lvl   <= LVL_CW'(LVL_N);
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          for (int i = 0; i < CAND_N; i++) begin
            cand_val[i] <= red_val[i];
            cand_idx[i] <= red_idx[i];
            cand_ok[i]  <= red_ok[i];
          end
          lvl <= lvl - LVL_CW'(1);
          if (lvl == LVL_CW'(1)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (!cand_ok[0]) begin
            out_status <= STAT_EMPTY;
            m_tdata    <= '0;
            out_src    <= '0;
            state      <= S_IDLE;
          end else begin
            out_status    <= STAT_OK;
            m_tdata       <= cand_val[0];
            out_src       <= IDX_W'(win);
            rd_pos[win]   <= pos_inc;
            fill_cnt[win] <= win_fill - CNT_W'(1);
            take_list     <= win;
            if (win_fill > CNT_W'(1)) begin
              state <= S_REFILL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_REFILL: begin
          head_val[take_list] <= $signed(ram_rdata);
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `KWM_ASSERT_NEXT(a_load_result, s_fire && (in_op == OP_LOAD), m_tvalid,
    "load word gave no result")
  `KWM_ASSERT_NOW(a_winner_live, (state == S_COMMIT) && cand_ok[0],
    fill_cnt[cand_idx[0]] != '0, "take winner is an empty list")
  `KWM_ASSERT_NOW(a_refill_live, state == S_REFILL, fill_cnt[take_list] != '0,
    "head refill for an empty list")
  `KWM_ASSERT_NOW(a_fill_bound, list_ok, fill_cnt[list_sel] <= CNT_W'(LIST_DEPTH),
    "fill count above list depth")

endmodule

`default_nettype wire

[bench/k_way_sorted_merge_unit_tb.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit_tb
// Self-checking bench for the k-way sorted merge unit. A directed table
// covers empty takes, extreme values, equal and out-of-order loads and list
// draining. After it come random runs of ascending loads, takes, full-list
// floods and noise. Every result word is checked against a predictor of the
// list contents while the sender and the receiver both idle at random.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_unit_tb;
  import kwm_pkg::*;

  localparam int RUN_ITEMS   = 650;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  // one result word, split into its fields
  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  value;
    logic [IDX_W-1:0]         src;
  } merge_result_t;

  // one row of directed stimulus; res is used only when fixed is set
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic              fixed;
    merge_result_t     res;
  } stim_row_t;

  typedef enum {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_t;

  localparam int DIR_ROWS = 21;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_TAKE, 3'd5, 32'hDEADBEEF, 1'b1, '{STAT_EMPTY, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd0, 32'h80000000, 1'b1, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd0, 32'h80000000, 1'b1, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd0, 32'hFFFFFFFB, 1'b1, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd0, 32'hFFFFFFFA, 1'b1, '{STAT_ORDER, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd7, 32'h7FFFFFFF, 1'b1, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd7, 32'h00000000, 1'b1, '{STAT_ORDER, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd3, 32'hFFFFFFFB, 1'b1, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd5, 32'h00000000, 1'b1, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd7, 32'hFFFFFFFF, 1'b1, '{STAT_OK, 32'h80000000, 3'd0}},
    '{OP_TAKE, 3'd0, 32'h00000000, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd2, 32'h5A5A5A5A, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd4, 32'hA5A5A5A5, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd1, 32'h00000001, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd6, 32'h7FFFFFFF, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd3, 32'h80000000, 1'b1, '{STAT_EMPTY, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd7, 32'h80000000, 1'b1, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_LOAD, 3'd2, 32'h12345678, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd0, 32'h00000000, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd0, 32'h00000000, 1'b0, '{STAT_OK, 32'h0, 3'd0}},
    '{OP_TAKE, 3'd0, 32'h00000000, 1'b1, '{STAT_EMPTY, 32'h0, 3'd0}}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [VAL_W-1:0]           s_tdata = '0;   // value
  logic [IDX_W:0]             s_tuser = '0;   // operation, list_index
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [VAL_W-1:0]           m_tdata;        // merged_value
  logic [STAT_W+IDX_W-1:0]    m_tuser;        // status, source_list

  // predicted list contents
  logic signed [VAL_W-1:0] list_mem [LIST_COUNT][LIST_DEPTH];
  int unsigned             list_head [LIST_COUNT];
  int unsigned             list_fill [LIST_COUNT];
  logic signed [VAL_W-1:0] list_tail [LIST_COUNT];

  merge_result_t expected_words [$];
  int            mismatches = 0;
  int            items_sent = 0;
  int            burst_left = 0;
  int            cycles = 0;
  rx_mode_t      rx_mode = RX_FREE;
  logic [12:0]   rx_pattern = 13'b1011001110110;

  k_way_sorted_merge_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // apply one word to the predicted lists and return its result
  function automatic merge_result_t merge_step(op_t op, logic [IDX_W-1:0] idx,
                                               logic signed [VAL_W-1:0] val);
    merge_result_t           r;
    int                      best;
    logic signed [VAL_W-1:0] best_val;
    logic signed [VAL_W-1:0] head_val;
    r.status = STAT_OK;
    r.value  = '0;
    r.src    = '0;
    best     = -1;
    best_val = '0;
    if (op == OP_LOAD) begin
      if (int'(idx) >= LIST_COUNT || list_fill[idx] >= LIST_DEPTH) begin
        r.status = STAT_FULL;
      end else if (list_fill[idx] != 0 && val < list_tail[idx]) begin
        r.status = STAT_ORDER;
      end else begin
        list_mem[idx][(list_head[idx] + list_fill[idx]) % LIST_DEPTH] = val;
        list_fill[idx]++;
        list_tail[idx] = val;
      end
    end else begin
      // strict less-than keeps the lowest list on a tie
      for (int i = 0; i < LIST_COUNT; i++) begin
        if (list_fill[i] != 0) begin
          head_val = list_mem[i][list_head[i]];
          if (best < 0 || head_val < best_val) begin
            best     = i;
            best_val = head_val;
          end
        end
      end
      if (best < 0) begin
        r.status = STAT_EMPTY;
      end else begin
        list_head[best] = (list_head[best] + 1) % LIST_DEPTH;
        list_fill[best]--;
        r.value = best_val;
        r.src   = IDX_W'(best);
      end
    end
    return r;
  endfunction

  // value that keeps a list ascending, now and then a tie or a big step
  function automatic logic [VAL_W-1:0] ascending_value(int list);
    longint      sum;
    int unsigned step;
    if (list_fill[list] == 0) begin
      if ($urandom_range(0, 1) == 0) return $urandom();
      return $urandom_range(0, 64) - 32;
    end
    case ($urandom_range(0, 3))
      0:       step = 0;
      1:       step = $urandom_range(1, 16);
      2:       step = $urandom_range(1, 65536);
      default: step = $urandom() >> 4;
    endcase
    sum = longint'(list_tail[list]) + longint'(step);
    if (sum > 64'sh7FFFFFFF) sum = 64'sh7FFFFFFF;
    return sum[VAL_W-1:0];
  endfunction

  // send one word in bursts with random gaps, predict at accept
  task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                           logic fixed, merge_result_t fixed_res);
    int            gap;
    merge_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= {idx, op};
    do @(posedge clk); while (!s_tready);
    r = merge_step(op, idx, val);
    expected_words.push_back(fixed ? fixed_res : r);
    burst_left--;
    items_sent++;
  endtask

  // hold the sender until every expected word has come back
  task automatic wait_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // receiver backpressure, switching mode now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    case (rx_mode)
      RX_FREE: begin
        m_tready <= 1'b1;
      end
      RX_PATTERN: begin
        m_tready   <= rx_pattern[0];
        rx_pattern <= {rx_pattern[0], rx_pattern[12:1]};
      end
      default: begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    merge_result_t got;
    merge_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser[STAT_W-1:0]);
      got.value  = m_tdata;
      got.src    = m_tuser[STAT_W+IDX_W-1:STAT_W];
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d value %0d src %0d",
                   got.status, got.value, got.src);
      end else begin
        want = expected_words.pop_front();
        if (got.status !== want.status || got.value !== want.value ||
            got.src !== want.src) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d value %0d src %0d, got %0d %0d %0d",
                     want.status, want.value, want.src, got.status, got.value, got.src);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int            kind;
    int            count;
    int            list;
    logic [VAL_W-1:0] val;
    merge_result_t none;
    bit            paused;
    none   = '0;
    paused = 1'b0;
    for (int i = 0; i < LIST_COUNT; i++) begin
      list_head[i] = 0;
      list_fill[i] = 0;
      list_tail[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].val,
                DIRECTED[i].fixed, DIRECTED[i].res);
    wait_results();

    // random runs; the first one floods a list past full
    kind = 4;
    while (items_sent < RUN_ITEMS) begin
      case (kind)
        0, 1: begin
          // ascending loads into one list, a few out of order
          list  = $urandom_range(0, LIST_COUNT - 1);
          count = $urandom_range(1, 12);
          repeat (count) begin
            if (list_fill[list] != 0 && $urandom_range(0, 9) == 0)
              val = list_tail[list] - $urandom_range(1, 1000);
            else
              val = ascending_value(list);
            send_word(OP_LOAD, IDX_W'(list), val, 1'b0, none);
          end
        end
        2, 3: begin
          // takes with random don't-care fields
          count = $urandom_range(1, 12);
          repeat (count)
            send_word(OP_TAKE, IDX_W'($urandom()), $urandom(), 1'b0, none);
        end
        4: begin
          // fill one list until it reports full
          list  = $urandom_range(0, LIST_COUNT - 1);
          count = LIST_DEPTH - list_fill[list] + 2;
          repeat (count)
            send_word(OP_LOAD, IDX_W'(list), ascending_value(list), 1'b0, none);
        end
        5, 6: begin
          // interleaved well-formed loads and takes across lists
          count = $urandom_range(2, 16);
          repeat (count) begin
            list = $urandom_range(0, LIST_COUNT - 1);
            if ($urandom_range(0, 1) == 0)
              send_word(OP_LOAD, IDX_W'(list), ascending_value(list), 1'b0, none);
            else
              send_word(OP_TAKE, IDX_W'(list), $urandom(), 1'b0, none);
          end
        end
        default: begin
          // noise
          count = $urandom_range(1, 6);
          repeat (count)
            send_word(op_t'($urandom_range(0, 1)), IDX_W'($urandom()), $urandom(),
                      1'b0, none);
        end
      endcase
      if (!paused && items_sent >= RUN_ITEMS / 2) begin
        wait_results();
        paused = 1'b1;
      end
      kind = ($urandom_range(0, 19) == 0) ? 4 : $urandom_range(0, 7);
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
